/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/gmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gmd_pkg;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    localparam int ROW_W = 3;
    localparam int COL_W = 3;
    localparam int DIM_W = 4;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_POP_WAIT,
        ST_VIS_WAIT,
        ST_EMIT,
        ST_NB_REQ,
        ST_NB_WAIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        NB_RIGHT = 2'd0,
        NB_DOWN  = 2'd1,
        NB_UP    = 2'd2,
        NB_LEFT  = 2'd3
    } nb_dir_t;

endpackage

`default_nettype wire

/* design/gmd_cell_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gmd_cell_if;
    logic                      valid;
    logic                      ready;
    logic [gmd_pkg::ROW_W-1:0] cell_row;
    logic [gmd_pkg::COL_W-1:0] cell_col;
    logic                      cell_open;
    logic                      start_search;

    modport source (output valid, cell_row, cell_col, cell_open, start_search, input ready);
    modport sink   (input valid, cell_row, cell_col, cell_open, start_search, output ready);
endinterface

`default_nettype wire

/* design/gmd_visit_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface gmd_visit_if;
    logic                      valid;
    logic                      ready;
    logic [gmd_pkg::ROW_W-1:0] visit_row;
    logic [gmd_pkg::COL_W-1:0] visit_col;
    logic                      goal_reached;
    logic                      no_open_cell;
    logic                      last_visit;

    modport source (output valid, visit_row, visit_col, goal_reached, no_open_cell,
                    last_visit, input ready);
    modport sink   (input valid, visit_row, visit_col, goal_reached, no_open_cell,
                    last_visit, output ready);
endinterface

`default_nettype wire

/* design/grid_maze_dfs_core.sv */
// Loading: one cell transaction per cycle while idle, no result; input is held off during a search.
// Search: a sweep over every open-map entry, then per popped stack entry the states POP, POP_WAIT and
// VIS_WAIT, plus EMIT for a new visit and NB_REQ (and NB_WAIT when in grid) per neighbor probe (one open-map port).
// The first result leaves after the sweep when there is no open cell, and after the first emit when the
// start cell is the goal; otherwise a visit leaves once the next visit or the run end is known.
// rst_n (async, low) clears control state; registers reset to 8, maps are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module grid_maze_dfs_core #(
    parameter int MAX_ROWS = gmd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmd_pkg::MAX_COLS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    gmd_cell_if.sink                         in_ch,
    gmd_visit_if.source                      out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gmd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [gmd_pkg::DATA_W-1:0]  pwdata,
    output logic      [gmd_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    // Maps are addressed by {row, col}; MAX_ROWS and MAX_COLS bound the used area and size the stack
    localparam int CELL_COUNT  = MAX_ROWS * MAX_COLS;
    localparam int STACK_DEPTH = CELL_COUNT * 4 + 1;
    localparam int IDX_W       = gmd_pkg::ROW_W + gmd_pkg::COL_W;
    localparam int MAP_DEPTH   = 1 << IDX_W;
    localparam int SC_W        = $clog2(MAP_DEPTH + 1);
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DIM_W       = gmd_pkg::DIM_W;

    // Configuration registers
    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gmd_pkg::DIM_RESET;
            cols_reg <= gmd_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (gmd_pkg::reg_idx_t'(paddr[2]))
                gmd_pkg::REG_ROWS: rows_reg <= pwdata[DIM_W-1:0];
                gmd_pkg::REG_COLS: cols_reg <= pwdata[DIM_W-1:0];
                default:           rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (gmd_pkg::reg_idx_t'(paddr[2]))
            gmd_pkg::REG_ROWS: prdata[DIM_W-1:0] = rows_reg;
            gmd_pkg::REG_COLS: prdata[DIM_W-1:0] = cols_reg;
            default:           prdata = '0;
        endcase
    end

    // Clamp the used area to [2, max]
    logic [DIM_W-1:0] nr, nc;
    assign nr = (rows_reg < DIM_W'(2)) ? DIM_W'(2) :
                (rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;
    assign nc = (cols_reg < DIM_W'(2)) ? DIM_W'(2) :
                (cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg;

    // Control and payload registers
    gmd_pkg::state_t  state_reg, state_next;
    gmd_pkg::nb_dir_t nb_reg, nb_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [SC_W-1:0]  scan_reg, scan_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0] v_reg, v_next;
    logic [IDX_W-1:0] nb_idx_reg, nb_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [DIM_W-1:0] pend_row_reg, pend_row_next;
    logic [DIM_W-1:0] pend_col_reg, pend_col_next;
    logic             pend_goal_reg, pend_goal_next;
    logic             pend_none_reg, pend_none_next;
    logic             out_valid_reg, out_valid_next;
    logic [DIM_W-1:0] out_row_reg, out_row_next;
    logic [DIM_W-1:0] out_col_reg, out_col_next;
    logic             out_goal_reg, out_goal_next;
    logic             out_none_reg, out_none_next;
    logic             out_last_reg, out_last_next;

    // Memory ports
    logic             open_we, open_wdata, open_rdata;
    logic [IDX_W-1:0] open_waddr, open_raddr;
    logic             vis_we, vis_wdata, vis_rdata;
    logic [IDX_W-1:0] vis_waddr;
    logic             stk_we;
    logic [SA_W-1:0]  stk_waddr, stk_raddr;
    logic [IDX_W-1:0] stk_wdata, stk_rdata;

    gmd_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_open_map (
        .clk(clk), .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
        .raddr(open_raddr), .rdata(open_rdata)
    );

    gmd_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_visited_map (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(stk_rdata), .rdata(vis_rdata)
    );

    gmd_ram #(.WIDTH(IDX_W), .DEPTH(STACK_DEPTH)) u_cell_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Coordinates of the visited cell and of the cell checked by the sweep
    logic [IDX_W-1:0] scan_addr;
    logic [DIM_W-1:0] v_row, v_col, sa_row, sa_col;
    assign scan_addr = scan_reg[IDX_W-1:0] - IDX_W'(1);
    assign v_row  = DIM_W'(v_reg[IDX_W-1:gmd_pkg::COL_W]);
    assign v_col  = DIM_W'(v_reg[gmd_pkg::COL_W-1:0]);
    assign sa_row = DIM_W'(scan_addr[IDX_W-1:gmd_pkg::COL_W]);
    assign sa_col = DIM_W'(scan_addr[gmd_pkg::COL_W-1:0]);

    // Neighbor candidate for the current probe
    logic [DIM_W-1:0] nb_row, nb_col;
    logic             nb_ok;
    always_comb
    begin
        nb_row = v_row;
        nb_col = v_col;
        nb_ok  = 1'b1;
        unique case (nb_reg)
            gmd_pkg::NB_RIGHT: nb_col = v_col + DIM_W'(1);
            gmd_pkg::NB_DOWN:  nb_row = v_row + DIM_W'(1);
            gmd_pkg::NB_UP:
            begin
                nb_row = v_row - DIM_W'(1);
                nb_ok  = (v_row != '0);
            end
            gmd_pkg::NB_LEFT:
            begin
                nb_col = v_col - DIM_W'(1);
                nb_ok  = (v_col != '0);
            end
            default: nb_ok = 1'b0;
        endcase
        nb_ok = nb_ok && (nb_row < nr) && (nb_col < nc);
    end

    logic in_fire, slot_free, cell_in_grid;
    assign in_ch.ready  = (state_reg == gmd_pkg::ST_IDLE);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign slot_free    = !out_valid_reg || out_ch.ready;
    assign cell_in_grid = ({1'b0, in_ch.cell_row} < DIM_W'(MAX_ROWS)) &&
                          ({1'b0, in_ch.cell_col} < DIM_W'(MAX_COLS));

    always_comb
    begin
        state_next      = state_reg;
        nb_next         = nb_reg;
        sp_next         = sp_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        start_next      = start_reg;
        v_next          = v_reg;
        nb_idx_next     = nb_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_goal_next  = pend_goal_reg;
        pend_none_next  = pend_none_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_goal_next   = out_goal_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;

        open_we    = 1'b0;
        open_waddr = {in_ch.cell_row, in_ch.cell_col};
        open_wdata = in_ch.cell_open;
        open_raddr = '0;
        vis_we     = 1'b0;
        vis_waddr  = scan_reg[IDX_W-1:0];
        vis_wdata  = 1'b0;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[SA_W-1:0];
        stk_wdata  = nb_idx_reg;
        stk_raddr  = SA_W'(sp_reg - SP_W'(1));

        unique case (state_reg)
            gmd_pkg::ST_IDLE:
            begin
                // Store an in-grid cell; the start transaction opens a search
                if (in_fire)
                begin
                    open_we = cell_in_grid;
                    if (in_ch.start_search)
                    begin
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = gmd_pkg::ST_SCAN;
                    end
                end
            end
            gmd_pkg::ST_SCAN:
            begin
                // Clear visited and look for the first open used cell
                if (scan_reg < SC_W'(MAP_DEPTH))
                begin
                    open_raddr = scan_reg[IDX_W-1:0];
                    vis_we     = 1'b1;
                    scan_next  = scan_reg + SC_W'(1);
                end
                if (scan_reg != '0 && !found_reg && open_rdata &&
                    sa_row < nr && sa_col < nc)
                begin
                    found_next = 1'b1;
                    start_next = scan_addr;
                end
                if (scan_reg == SC_W'(MAP_DEPTH))
                begin
                    if (found_next)
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = start_next;
                        sp_next    = SP_W'(1);
                        state_next = gmd_pkg::ST_POP;
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_row_next   = '0;
                        pend_col_next   = '0;
                        pend_goal_next  = 1'b0;
                        pend_none_next  = 1'b1;
                        state_next      = gmd_pkg::ST_FLUSH;
                    end
                end
            end
            gmd_pkg::ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = gmd_pkg::ST_FLUSH;
                end
                else
                begin
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = gmd_pkg::ST_POP_WAIT;
                end
            end
            gmd_pkg::ST_POP_WAIT:
            begin
                // Stack data is out; visited read at the same address
                v_next     = stk_rdata;
                state_next = gmd_pkg::ST_VIS_WAIT;
            end
            gmd_pkg::ST_VIS_WAIT:
            begin
                if (vis_rdata)
                begin
                    state_next = gmd_pkg::ST_POP;
                end
                else
                begin
                    vis_we     = 1'b1;
                    vis_waddr  = v_reg;
                    vis_wdata  = 1'b1;
                    state_next = gmd_pkg::ST_EMIT;
                end
            end
            gmd_pkg::ST_EMIT:
            begin
                // Hold the newest visit back until it is known whether it ends the run
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = pend_row_reg;
                        out_col_next   = pend_col_reg;
                        out_goal_next  = pend_goal_reg;
                        out_none_next  = pend_none_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_row_next   = v_row;
                    pend_col_next   = v_col;
                    pend_goal_next  = (v_row == nr - DIM_W'(1));
                    pend_none_next  = 1'b0;
                    nb_next         = gmd_pkg::NB_RIGHT;
                    state_next      = pend_goal_next ? gmd_pkg::ST_FLUSH : gmd_pkg::ST_NB_REQ;
                end
            end
            gmd_pkg::ST_NB_REQ:
            begin
                nb_idx_next = {nb_row[gmd_pkg::ROW_W-1:0], nb_col[gmd_pkg::COL_W-1:0]};
                open_raddr  = nb_idx_next;
                if (nb_ok)
                begin
                    state_next = gmd_pkg::ST_NB_WAIT;
                end
                else if (nb_reg == gmd_pkg::NB_LEFT)
                begin
                    state_next = gmd_pkg::ST_POP;
                end
                else
                begin
                    nb_next = gmd_pkg::nb_dir_t'(nb_reg + 2'd1);
                end
            end
            gmd_pkg::ST_NB_WAIT:
            begin
                // Push an open neighbor while the stack has room
                if (open_rdata && sp_reg < SP_W'(STACK_DEPTH))
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg + SP_W'(1);
                end
                if (nb_reg == gmd_pkg::NB_LEFT)
                begin
                    state_next = gmd_pkg::ST_POP;
                end
                else
                begin
                    nb_next    = gmd_pkg::nb_dir_t'(nb_reg + 2'd1);
                    state_next = gmd_pkg::ST_NB_REQ;
                end
            end
            gmd_pkg::ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = pend_row_reg;
                    out_col_next    = pend_col_reg;
                    out_goal_next   = pend_goal_reg;
                    out_none_next   = pend_none_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = gmd_pkg::ST_IDLE;
                end
            end
            default: state_next = gmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gmd_pkg::ST_IDLE;
            nb_reg         <= gmd_pkg::NB_RIGHT;
            sp_reg         <= '0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nb_reg         <= nb_next;
            sp_reg         <= sp_next;
            scan_reg       <= scan_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg     <= start_next;
        v_reg         <= v_next;
        nb_idx_reg    <= nb_idx_next;
        pend_row_reg  <= pend_row_next;
        pend_col_reg  <= pend_col_next;
        pend_goal_reg <= pend_goal_next;
        pend_none_reg <= pend_none_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_goal_reg  <= out_goal_next;
        out_none_reg  <= out_none_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.visit_row    = out_row_reg[gmd_pkg::ROW_W-1:0];
    assign out_ch.visit_col    = out_col_reg[gmd_pkg::COL_W-1:0];
    assign out_ch.goal_reached = out_goal_reg;
    assign out_ch.no_open_cell = out_none_reg;
    assign out_ch.last_visit   = out_last_reg;

    `ASSERT_ALWAYS(a_sp_bound, clk, rst_n, sp_reg <= SP_W'(STACK_DEPTH))
    `ASSERT_NEXT(a_seed_push, clk, rst_n,
        state_reg == gmd_pkg::ST_SCAN && state_next == gmd_pkg::ST_POP, sp_reg == SP_W'(1))
    `ASSERT_ALWAYS(a_none_last, clk, rst_n,
        !(out_valid_reg && out_none_reg) || out_last_reg)
    `ASSERT_ALWAYS(a_flush_pending, clk, rst_n,
        state_reg != gmd_pkg::ST_FLUSH || pend_valid_reg)

endmodule

`default_nettype wire

/* design/gmd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module gmd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
